@@ hdl/pcsm_pkg.sv @@
// types, constants and codes shared by the p-code stack machine step core
// no dependencies
package pcsm_pkg;

	localparam int WORD_W      = 32;
	localparam int PTR_W       = 9;
	localparam int PC_W        = 11;
	localparam int STACK_DEPTH = 512;
	localparam int ADDR_W      = 34;
	localparam int OPC_W       = 3;
	localparam int LVL_IN_W    = 2;
	localparam int FAULT_W     = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 56;
	localparam int DIV_CNT_W   = 6;

	localparam logic [OPC_W-1:0] OP_LIT = 3'd0;
	localparam logic [OPC_W-1:0] OP_OPR = 3'd1;
	localparam logic [OPC_W-1:0] OP_LOD = 3'd2;
	localparam logic [OPC_W-1:0] OP_STO = 3'd3;
	localparam logic [OPC_W-1:0] OP_CAL = 3'd4;
	localparam logic [OPC_W-1:0] OP_INT = 3'd5;
	localparam logic [OPC_W-1:0] OP_JMP = 3'd6;
	localparam logic [OPC_W-1:0] OP_JPC = 3'd7;

	localparam logic [WORD_W-1:0] OPR_RET = 32'd0;
	localparam logic [WORD_W-1:0] OPR_NEG = 32'd1;
	localparam logic [WORD_W-1:0] OPR_ADD = 32'd2;
	localparam logic [WORD_W-1:0] OPR_SUB = 32'd3;
	localparam logic [WORD_W-1:0] OPR_MUL = 32'd4;
	localparam logic [WORD_W-1:0] OPR_DIV = 32'd5;
	localparam logic [WORD_W-1:0] OPR_ODD = 32'd6;
	localparam logic [WORD_W-1:0] OPR_EQ  = 32'd7;
	localparam logic [WORD_W-1:0] OPR_NE  = 32'd8;
	localparam logic [WORD_W-1:0] OPR_LT  = 32'd9;
	localparam logic [WORD_W-1:0] OPR_GE  = 32'd10;
	localparam logic [WORD_W-1:0] OPR_GT  = 32'd11;
	localparam logic [WORD_W-1:0] OPR_LE  = 32'd12;

	localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_DIV0  = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_RANGE = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISPATCH, ST_WALK_RD, ST_WALK_D, ST_LIT_WR,
		ST_RET_R3, ST_RET_R2, ST_RET_UPD, ST_UN_RD, ST_UN_WR,
		ST_BIN_RY, ST_BIN_RX, ST_BIN_X, ST_DIV_INIT, ST_DIV_RUN, ST_BIN_WR,
		ST_LOD_RD, ST_LOD_WR, ST_STO_RD, ST_STO_WR,
		ST_CAL_W1, ST_CAL_W2, ST_CAL_W3, ST_INT_UPD, ST_JMP_UPD,
		ST_JPC_RD, ST_JPC_UPD, ST_TOP_RD, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		AS_T, AS_TM1, AS_TP1, AS_TP2, AS_TP3, AS_B1, AS_B1OPD, AS_BP1, AS_BP2
	} addr_sel_t;

	typedef enum logic [2:0] {
		WS_OPD, WS_RD, WS_UN, WS_ALU, WS_B1, WS_BASE, WS_PC
	} wdata_sel_t;

	typedef enum logic [2:0] {TS_KEEP, TS_TP1, TS_TM1, TS_NT, TS_INT} top_sel_t;
	typedef enum logic [1:0] {PS_KEEP, PS_OPD, PS_RET, PS_JPC} pc_sel_t;
	typedef enum logic [1:0] {BS_KEEP, BS_TP1, BS_RET} base_sel_t;
	typedef enum logic [2:0] {OK_RET, OK_UN, OK_BIN, OK_DIV, OK_NONE} opr_kind_t;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic       wr_en;
		addr_sel_t  addr_sel;
		wdata_sel_t wdata_sel;
		top_sel_t   top_sel;
		pc_sel_t    pc_sel;
		base_sel_t  base_sel;
		logic       b1_ld;
		logic       y_ld;
		logic       div_start;
		logic       div_step;
		logic       x_ld;
		logic       out_ld;
	} cmd_t;

	typedef struct packed {
		opr_kind_t opr_kind;
		logic      div_done;
		logic      out_free;
	} stat_t;

endpackage

@@ hdl/pcsm_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module pcsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hdl/pcsm_ctrl.sv @@
// sequencer for the step core: one state walk per instruction
// depends on pcsm_pkg
module pcsm_ctrl #(
	parameter int MAX_LEVEL = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pcsm_pkg::OPC_W-1:0]    opcode,
	input  logic [pcsm_pkg::LVL_IN_W-1:0] level,
	input  pcsm_pkg::stat_t               stat,
	output pcsm_pkg::cmd_t                cmd
);
	import pcsm_pkg::*;

	localparam int LVL_W = $clog2(MAX_LEVEL + 1);

	state_t             state_q, state_nx;
	logic [OPC_W-1:0]   op_q;
	logic [LVL_W-1:0]   cnt_q;
	logic [3:0]         lvl_ext, lvl_eff;
	state_t             walk_target;

	assign lvl_ext = 4'(level);
	assign lvl_eff = (lvl_ext > 4'(MAX_LEVEL)) ? 4'(MAX_LEVEL) : lvl_ext;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		unique case (op_q)
			OP_LOD:  walk_target = ST_LOD_RD;
			OP_STO:  walk_target = ST_STO_RD;
			default: walk_target = ST_CAL_W1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_LIT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE && in_valid) begin
				op_q  <= opcode;
				cnt_q <= lvl_eff[LVL_W-1:0];
			end else if (state_q == ST_WALK_RD) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_nx = ST_DISPATCH;
			ST_DISPATCH: begin
				unique case (op_q)
					OP_LIT: state_nx = ST_LIT_WR;
					OP_OPR: begin
						unique case (stat.opr_kind)
							OK_RET:  state_nx = ST_RET_R3;
							OK_UN:   state_nx = ST_UN_RD;
							OK_BIN:  state_nx = ST_BIN_RY;
							OK_DIV:  state_nx = ST_BIN_RY;
							default: state_nx = ST_TOP_RD;
						endcase
					end
					OP_LOD, OP_STO, OP_CAL:
						state_nx = (cnt_q != '0) ? ST_WALK_RD : walk_target;
					OP_INT:  state_nx = ST_INT_UPD;
					OP_JMP:  state_nx = ST_JMP_UPD;
					default: state_nx = ST_JPC_RD;
				endcase
			end
			ST_WALK_RD:  state_nx = ST_WALK_D;
			ST_WALK_D:   state_nx = (cnt_q != '0) ? ST_WALK_RD : walk_target;
			ST_LIT_WR:   state_nx = ST_TOP_RD;
			ST_RET_R3:   state_nx = ST_RET_R2;
			ST_RET_R2:   state_nx = ST_RET_UPD;
			ST_RET_UPD:  state_nx = ST_TOP_RD;
			ST_UN_RD:    state_nx = ST_UN_WR;
			ST_UN_WR:    state_nx = ST_TOP_RD;
			ST_BIN_RY:   state_nx = ST_BIN_RX;
			ST_BIN_RX:   state_nx = ST_BIN_X;
			ST_BIN_X:    state_nx = (stat.opr_kind == OK_DIV) ? ST_DIV_INIT : ST_BIN_WR;
			ST_DIV_INIT: state_nx = ST_DIV_RUN;
			ST_DIV_RUN:  if (stat.div_done) state_nx = ST_BIN_WR;
			ST_BIN_WR:   state_nx = ST_TOP_RD;
			ST_LOD_RD:   state_nx = ST_LOD_WR;
			ST_LOD_WR:   state_nx = ST_TOP_RD;
			ST_STO_RD:   state_nx = ST_STO_WR;
			ST_STO_WR:   state_nx = ST_TOP_RD;
			ST_CAL_W1:   state_nx = ST_CAL_W2;
			ST_CAL_W2:   state_nx = ST_CAL_W3;
			ST_CAL_W3:   state_nx = ST_TOP_RD;
			ST_INT_UPD:  state_nx = ST_TOP_RD;
			ST_JMP_UPD:  state_nx = ST_TOP_RD;
			ST_JPC_RD:   state_nx = ST_JPC_UPD;
			ST_JPC_UPD:  state_nx = ST_TOP_RD;
			ST_TOP_RD:   state_nx = ST_OUT;
			ST_OUT:      if (stat.out_free) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '{load: 1'b0, rd_en: 1'b0, wr_en: 1'b0, addr_sel: AS_T,
			wdata_sel: WS_OPD, top_sel: TS_KEEP, pc_sel: PS_KEEP,
			base_sel: BS_KEEP, b1_ld: 1'b0, y_ld: 1'b0, div_start: 1'b0,
			div_step: 1'b0, x_ld: 1'b0, out_ld: 1'b0};
		unique case (state_q)
			ST_IDLE:    cmd.load = in_valid;
			ST_WALK_RD: begin cmd.rd_en = 1'b1; cmd.addr_sel = AS_B1; end
			ST_WALK_D:  cmd.b1_ld = 1'b1;
			ST_LIT_WR: begin
				cmd.wr_en = 1'b1; cmd.addr_sel = AS_TP1; cmd.wdata_sel = WS_OPD;
				cmd.top_sel = TS_TP1;
			end
			ST_RET_R3:  begin cmd.rd_en = 1'b1; cmd.addr_sel = AS_BP2; end
			ST_RET_R2: begin
				cmd.y_ld = 1'b1; cmd.rd_en = 1'b1; cmd.addr_sel = AS_BP1;
			end
			ST_RET_UPD: begin
				cmd.top_sel = TS_NT; cmd.pc_sel = PS_RET; cmd.base_sel = BS_RET;
			end
			ST_UN_RD:   begin cmd.rd_en = 1'b1; cmd.addr_sel = AS_T; end
			ST_UN_WR: begin
				cmd.wr_en = 1'b1; cmd.addr_sel = AS_T; cmd.wdata_sel = WS_UN;
			end
			ST_BIN_RY:  begin cmd.rd_en = 1'b1; cmd.addr_sel = AS_T; end
			ST_BIN_RX: begin
				cmd.y_ld = 1'b1; cmd.rd_en = 1'b1; cmd.addr_sel = AS_TM1;
			end
			ST_BIN_X:    cmd.x_ld = 1'b1;
			ST_DIV_INIT: cmd.div_start = 1'b1;
			ST_DIV_RUN:  cmd.div_step = 1'b1;
			ST_BIN_WR: begin
				cmd.wr_en = 1'b1; cmd.addr_sel = AS_TM1; cmd.wdata_sel = WS_ALU;
				cmd.top_sel = TS_TM1;
			end
			ST_LOD_RD:  begin cmd.rd_en = 1'b1; cmd.addr_sel = AS_B1OPD; end
			ST_LOD_WR: begin
				cmd.wr_en = 1'b1; cmd.addr_sel = AS_TP1; cmd.wdata_sel = WS_RD;
				cmd.top_sel = TS_TP1;
			end
			ST_STO_RD:  begin cmd.rd_en = 1'b1; cmd.addr_sel = AS_T; end
			ST_STO_WR: begin
				cmd.wr_en = 1'b1; cmd.addr_sel = AS_B1OPD; cmd.wdata_sel = WS_RD;
				cmd.top_sel = TS_TM1;
			end
			ST_CAL_W1: begin
				cmd.wr_en = 1'b1; cmd.addr_sel = AS_TP1; cmd.wdata_sel = WS_B1;
			end
			ST_CAL_W2: begin
				cmd.wr_en = 1'b1; cmd.addr_sel = AS_TP2; cmd.wdata_sel = WS_BASE;
			end
			ST_CAL_W3: begin
				cmd.wr_en = 1'b1; cmd.addr_sel = AS_TP3; cmd.wdata_sel = WS_PC;
				cmd.base_sel = BS_TP1; cmd.pc_sel = PS_OPD;
			end
			ST_INT_UPD: cmd.top_sel = TS_INT;
			ST_JMP_UPD: cmd.pc_sel = PS_OPD;
			ST_JPC_RD:  begin cmd.rd_en = 1'b1; cmd.addr_sel = AS_T; end
			ST_JPC_UPD: begin cmd.pc_sel = PS_JPC; cmd.top_sel = TS_TM1; end
			ST_TOP_RD:  begin cmd.rd_en = 1'b1; cmd.addr_sel = AS_T; end
			ST_OUT:     cmd.out_ld = stat.out_free;
			default:    cmd.load = 1'b0;
		endcase
	end
endmodule

@@ hdl/pcsm_dpath.sv @@
// datapath: machine registers, stack ram, alu, serial divider, result register
// depends on pcsm_pkg and pcsm_ram
module pcsm_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pcsm_pkg::cmd_t                   cmd,
	output pcsm_pkg::stat_t                  stat,
	input  logic [pcsm_pkg::WORD_W-1:0]      in_operand,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pcsm_pkg::OUT_TDATA_W-1:0] out_data
);
	import pcsm_pkg::*;

	logic [WORD_W-1:0] opd_q, b1_q, y_q, x_q;
	logic [PTR_W-1:0]  top_q, base_q;
	logic [PC_W-1:0]   pc_q;
	logic              err_range_q, err_div_q, rd_zero_q;
	logic [3:1]        wvalid_q;

	logic [WORD_W-1:0] ram_rdata, rdata, wdata, alu, un_res, div_res;
	logic [ADDR_W-1:0] t_x, base_x, b1_x, opd_x, addr, top_nv, base_nv;
	logic              in_rng, top_ok, base_ok;
	logic [PTR_W-1:0]  mem_addr;
	logic              unwritten;

	// serial divider
	logic [WORD_W-1:0]    dv_rem_q, dv_quo_q, dv_den_q;
	logic                 dv_neg_q;
	logic [DIV_CNT_W-1:0] dv_cnt_q;
	logic [WORD_W:0]      rem_sh, diff;

	// result register
	logic                 ov_q;
	logic [OUT_TDATA_W-1:0] od_q;

	assign rdata  = rd_zero_q ? '0 : ram_rdata;
	assign t_x    = {{(ADDR_W-PTR_W){1'b0}}, top_q};
	assign base_x = {{(ADDR_W-PTR_W){1'b0}}, base_q};
	assign b1_x   = {{(ADDR_W-WORD_W){b1_q[WORD_W-1]}}, b1_q};
	assign opd_x  = {{(ADDR_W-WORD_W){opd_q[WORD_W-1]}}, opd_q};

	always_comb begin
		unique case (cmd.addr_sel)
			AS_T:     addr = t_x;
			AS_TM1:   addr = t_x - ADDR_W'(1);
			AS_TP1:   addr = t_x + ADDR_W'(1);
			AS_TP2:   addr = t_x + ADDR_W'(2);
			AS_TP3:   addr = t_x + ADDR_W'(3);
			AS_B1:    addr = b1_x;
			AS_B1OPD: addr = b1_x + opd_x;
			AS_BP1:   addr = base_x + ADDR_W'(1);
			default:  addr = base_x + ADDR_W'(2);
		endcase
	end

	// negative addresses wrap to huge unsigned values, so one compare covers both ends
	assign in_rng   = addr < ADDR_W'(STACK_DEPTH);
	assign mem_addr = addr[PTR_W-1:0];

	always_comb begin
		unwritten = 1'b0;
		if (mem_addr == PTR_W'(1)) unwritten = !wvalid_q[1];
		if (mem_addr == PTR_W'(2)) unwritten = !wvalid_q[2];
		if (mem_addr == PTR_W'(3)) unwritten = !wvalid_q[3];
	end

	always_comb begin
		unique case (cmd.top_sel)
			TS_TP1:  top_nv = t_x + ADDR_W'(1);
			TS_TM1:  top_nv = t_x - ADDR_W'(1);
			TS_NT:   top_nv = base_x - ADDR_W'(1);
			TS_INT:  top_nv = t_x + opd_x;
			default: top_nv = t_x;
		endcase
		unique case (cmd.base_sel)
			BS_TP1:  base_nv = t_x + ADDR_W'(1);
			BS_RET:  base_nv = {{(ADDR_W-WORD_W){rdata[WORD_W-1]}}, rdata};
			default: base_nv = base_x;
		endcase
	end
	assign top_ok  = top_nv < ADDR_W'(STACK_DEPTH);
	assign base_ok = base_nv < ADDR_W'(STACK_DEPTH);

	assign un_res  = (opd_q == OPR_NEG) ? (WORD_W'(0) - rdata) : {{(WORD_W-1){1'b0}}, rdata[0]};
	assign div_res = (y_q == '0) ? '0 : (dv_neg_q ? (WORD_W'(0) - dv_quo_q) : dv_quo_q);

	always_comb begin
		unique case (opd_q)
			OPR_ADD: alu = x_q + y_q;
			OPR_SUB: alu = x_q - y_q;
			OPR_MUL: alu = WORD_W'(x_q * y_q);
			OPR_DIV: alu = div_res;
			OPR_EQ:  alu = WORD_W'(x_q == y_q);
			OPR_NE:  alu = WORD_W'(x_q != y_q);
			OPR_LT:  alu = WORD_W'($signed(x_q) < $signed(y_q));
			OPR_GE:  alu = WORD_W'($signed(x_q) >= $signed(y_q));
			OPR_GT:  alu = WORD_W'($signed(x_q) > $signed(y_q));
			default: alu = WORD_W'($signed(x_q) <= $signed(y_q));
		endcase
	end

	always_comb begin
		unique case (cmd.wdata_sel)
			WS_OPD:  wdata = opd_q;
			WS_RD:   wdata = rdata;
			WS_UN:   wdata = un_res;
			WS_ALU:  wdata = alu;
			WS_B1:   wdata = b1_q;
			WS_BASE: wdata = WORD_W'(base_q);
			default: wdata = WORD_W'(pc_q);
		endcase
	end

	always_comb begin
		priority if (opd_q == OPR_RET) stat.opr_kind = OK_RET;
		else if (opd_q == OPR_NEG || opd_q == OPR_ODD) stat.opr_kind = OK_UN;
		else if (opd_q == OPR_DIV) stat.opr_kind = OK_DIV;
		else if (opd_q >= OPR_ADD && opd_q <= OPR_LE) stat.opr_kind = OK_BIN;
		else stat.opr_kind = OK_NONE;
	end
	assign stat.div_done = (dv_cnt_q == '0);
	assign stat.out_free = !ov_q || out_ready;

	pcsm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (cmd.wr_en && in_rng),
		.waddr (mem_addr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (mem_addr),
		.rdata (ram_rdata)
	);

	assign rem_sh = {dv_rem_q, dv_quo_q[WORD_W-1]};
	assign diff   = rem_sh - {1'b0, dv_den_q};

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) opd_q <= in_operand;
		if (cmd.load) b1_q <= WORD_W'(base_q);
		else if (cmd.b1_ld) b1_q <= rdata;
		if (cmd.y_ld) y_q <= rdata;
		if (cmd.x_ld) x_q <= rdata;
		if (cmd.rd_en) rd_zero_q <= !in_rng || unwritten;
		if (cmd.div_start) begin
			dv_rem_q <= '0;
			dv_quo_q <= x_q[WORD_W-1] ? (WORD_W'(0) - x_q) : x_q;
			dv_den_q <= y_q[WORD_W-1] ? (WORD_W'(0) - y_q) : y_q;
			dv_neg_q <= x_q[WORD_W-1] ^ y_q[WORD_W-1];
		end else if (cmd.div_step && dv_cnt_q != '0) begin
			if (!diff[WORD_W]) begin
				dv_rem_q <= diff[WORD_W-1:0];
				dv_quo_q <= {dv_quo_q[WORD_W-2:0], 1'b1};
			end else begin
				dv_rem_q <= rem_sh[WORD_W-1:0];
				dv_quo_q <= {dv_quo_q[WORD_W-2:0], 1'b0};
			end
		end
		if (cmd.out_ld) begin
			od_q <= {1'b0, err_range_q ? FAULT_RANGE : (err_div_q ? FAULT_DIV0 : FAULT_NONE),
				pc_q == '0, top_q, rdata, pc_q};
		end
	end

	// machine state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			base_q      <= PTR_W'(1);
			pc_q        <= '0;
			err_range_q <= 1'b0;
			err_div_q   <= 1'b0;
			wvalid_q    <= '0;
			dv_cnt_q    <= '0;
			ov_q        <= 1'b0;
		end else begin
			if (cmd.load) begin
				pc_q        <= pc_q + 1'b1;
				err_range_q <= 1'b0;
				err_div_q   <= 1'b0;
			end else begin
				if (((cmd.rd_en || cmd.wr_en) && !in_rng) || !top_ok || !base_ok)
					err_range_q <= 1'b1;
				if (cmd.div_start && y_q == '0) err_div_q <= 1'b1;
				unique case (cmd.pc_sel)
					PS_OPD:  pc_q <= opd_q[PC_W-1:0];
					PS_RET:  pc_q <= y_q[PC_W-1:0];
					PS_JPC:  if (rdata == '0) pc_q <= opd_q[PC_W-1:0];
					default: pc_q <= pc_q;
				endcase
			end
			top_q  <= top_nv[PTR_W-1:0];
			base_q <= base_nv[PTR_W-1:0];
			if (cmd.wr_en && in_rng) begin
				if (mem_addr == PTR_W'(1)) wvalid_q[1] <= 1'b1;
				if (mem_addr == PTR_W'(2)) wvalid_q[2] <= 1'b1;
				if (mem_addr == PTR_W'(3)) wvalid_q[3] <= 1'b1;
			end
			if (cmd.div_start) dv_cnt_q <= DIV_CNT_W'(WORD_W);
			else if (cmd.div_step && dv_cnt_q != '0) dv_cnt_q <= dv_cnt_q - 1'b1;
			if (cmd.out_ld) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;
endmodule

@@ hdl/pcode_stack_machine_step_core.sv @@
// top level of the p-code stack machine step core
// depends on pcsm_pkg, pcsm_ctrl, pcsm_dpath (and pcsm_ram below it)
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  opcode, level, operand
// m_axis    out  m_axis_tvalid / m_axis_tready  next_pc, top_value, stack_pointer,
//                                               halted, fault
//
// one instruction at a time: a new item is taken only once the current one has
// been handed to the result register; static links are followed one at a time,
// and a divide runs through the serial divider, one quotient bit a cycle; one
// stack ram access a cycle sets the pace of the other steps
// reset gives top 0, frame base 1, program counter 0; stack words 1 to 3 read as
// zero until written, no clearing pass
// a held result does not block the next item: the result register frees the input
// side, and only the final hand-over waits for m_axis_tready
module pcode_stack_machine_step_core #(
	parameter int MAX_LEVEL = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// opcode[2:0], level[4:3], operand[36:5], zero pad
	input  logic [pcsm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// next_pc[10:0], top_value[42:11], stack_pointer[51:43], halted[52],
	// fault[54:53], zero pad
	output logic [pcsm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import pcsm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: walks one instruction through its ram accesses
	pcsm_ctrl #(.MAX_LEVEL(MAX_LEVEL)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.opcode   (s_axis_tdata[OPC_W-1:0]),
		.level    (s_axis_tdata[OPC_W +: LVL_IN_W]),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers, stack ram, alu, divider and the result register
	pcsm_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_operand (s_axis_tdata[OPC_W+LVL_IN_W +: WORD_W]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

`ifndef NO_ASSERTIONS
	// fault code never takes the unused value
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[54:53] != 2'd3))
		else $error("fault code out of range");

	// halt mark agrees with the reported program counter
	a_halt_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[52] == (m_axis_tdata[10:0] == 11'd0)))
		else $error("halt mark does not match next pc");

	// after an accepted item the input side is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while busy");

	// a new result only appears after the item was taken in
	a_result_order: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
		else $error("result appeared too early");
`endif
endmodule

@@ tb/sv/tb_pcode_stack_machine_step_core.sv @@
// self-checking testbench for the p-code stack machine step core: a directed run,
// then random instruction streams under four idling phases, every result checked
// depends on pcsm_pkg and pcode_stack_machine_step_core
`timescale 1ns / 100ps

module tb_pcode_stack_machine_step_core;
	import pcsm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RUN_ITEMS   = 480;

	typedef struct {
		bit [10:0] npc;
		bit [31:0] tos;
		bit [8:0]  sp;
		bit        halt;
		bit [1:0]  flt;
	} step_out_t;

	// behavioural copy of the machine; tracks which stack words hold a defined value
	class pcode_machine;
		bit [31:0] mem [512];
		bit        known [512];
		bit [8:0]  top;
		bit [8:0]  base;
		bit [10:0] pc;
		bit        e_rng, e_div, undef;

		function new();
			foreach (mem[i]) begin
				mem[i] = '0;
				known[i] = (i >= 1 && i <= 3);
			end
			top = 0;
			base = 1;
			pc = 0;
		endfunction

		function void copy_from(pcode_machine o);
			mem = o.mem;
			known = o.known;
			top = o.top;
			base = o.base;
			pc = o.pc;
		endfunction

		function bit [31:0] rd(longint a);
			if (a < 0 || a >= STACK_DEPTH) begin
				e_rng = 1;
				return '0;
			end
			if (!known[a])
				undef = 1;
			return mem[a];
		endfunction

		function void wr(longint a, bit [31:0] v);
			if (a < 0 || a >= STACK_DEPTH) begin
				e_rng = 1;
				return;
			end
			mem[a] = v;
			known[a] = 1;
		endfunction

		function bit [8:0] nptr(longint v);
			if (v < 0 || v >= STACK_DEPTH)
				e_rng = 1;
			return v[8:0];
		endfunction

		function longint sw(bit [31:0] v);
			return longint'($signed(v));
		endfunction

		function void arith(longint num);
			longint t;
			bit [31:0] x, y, r;
			t = top;
			if (num == 0) begin
				// return: restore frame from the link cells
				x = rd(longint'(base) - 1 + 3);
				y = rd(longint'(base) - 1 + 2);
				top = nptr(longint'(base) - 1);
				pc = x[10:0];
				base = nptr(sw(y));
				return;
			end
			if (num == sw(OPR_NEG)) begin
				wr(t, -rd(t));
				return;
			end
			if (num == sw(OPR_ODD)) begin
				wr(t, rd(t) & 32'd1);
				return;
			end
			if (num < sw(OPR_ADD) || num > sw(OPR_LE))
				return;
			y = rd(t);
			x = rd(t - 1);
			case (num[31:0])
				OPR_ADD: r = x + y;
				OPR_SUB: r = x - y;
				OPR_MUL: r = x * y;
				OPR_DIV: begin
					if (y == 0) begin
						e_div = 1;
						r = 0;
					end else if (x == 32'h8000_0000 && y == '1)
						r = x;
					else
						r = $signed(x) / $signed(y);
				end
				OPR_EQ: r = {31'd0, x == y};
				OPR_NE: r = {31'd0, x != y};
				OPR_LT: r = {31'd0, $signed(x) < $signed(y)};
				OPR_GE: r = {31'd0, $signed(x) >= $signed(y)};
				OPR_GT: r = {31'd0, $signed(x) > $signed(y)};
				default: r = {31'd0, $signed(x) <= $signed(y)};
			endcase
			top = nptr(t - 1);
			wr(t - 1, r);
		endfunction

		// one instruction; bad is set when it would read a word that holds no defined value
		function void exec(bit [2:0] op, bit [1:0] lev, bit [31:0] opd_bits,
				output step_out_t res, output bit bad);
			longint opd, t, bb;
			bit [31:0] v;
			opd = sw(opd_bits);
			t = top;
			e_rng = 0;
			e_div = 0;
			undef = 0;
			pc = pc + 1;
			bb = base;
			if (op == OP_LOD || op == OP_STO || op == OP_CAL)
				for (int i = 0; i < lev; i++)
					bb = sw(rd(bb));
			case (op)
				OP_LIT: begin
					top = nptr(t + 1);
					wr(t + 1, opd_bits);
				end
				OP_OPR: arith(opd);
				OP_LOD: begin
					top = nptr(t + 1);
					v = rd(bb + opd);
					wr(t + 1, v);
				end
				OP_STO: begin
					v = rd(t);
					wr(bb + opd, v);
					top = nptr(t - 1);
				end
				OP_CAL: begin
					wr(t + 1, bb[31:0]);
					wr(t + 2, {23'd0, base});
					wr(t + 3, {21'd0, pc});
					base = nptr(t + 1);
					pc = opd_bits[10:0];
				end
				OP_INT: top = nptr(t + opd);
				OP_JMP: pc = opd_bits[10:0];
				default: begin
					if (rd(t) == 0)
						pc = opd_bits[10:0];
					top = nptr(t - 1);
				end
			endcase
			res.tos = rd(top);
			res.npc = pc;
			res.sp = top;
			res.halt = (pc == 0);
			res.flt = e_rng ? FAULT_RANGE : (e_div ? FAULT_DIV0 : FAULT_NONE);
			bad = undef;
		endfunction
	endclass

	class step_scoreboard;
		pcode_machine mach;
		step_out_t    due [$];
		int           mismatches;

		function new();
			mach = new();
			mismatches = 0;
		endfunction

		function void note_item(bit [IN_TDATA_W-1:0] d);
			step_out_t r;
			bit bad;
			mach.exec(d[2:0], d[4:3], d[36:5], r, bad);
			due.push_back(r);
		endfunction

		function void check_result(bit [OUT_TDATA_W-1:0] d);
			step_out_t e;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %h", d);
				return;
			end
			e = due.pop_front();
			if (d[10:0] != e.npc || d[42:11] != e.tos || d[51:43] != e.sp ||
					d[52] != e.halt || d[54:53] != e.flt) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp pc %0d top %h sp %0d halt %0b fault %0d, ",
						"got pc %0d top %h sp %0d halt %0b fault %0d"},
						e.npc, e.tos, e.sp, e.halt, e.flt,
						d[10:0], d[42:11], d[51:43], d[52], d[54:53]);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	step_scoreboard sb;
	pcode_machine   shadow;   // generator side copy, used to keep reads on defined words
	pcode_machine   trial;
	int             tx_idle;  // percent of cycles the sender idles
	int             rx_stall; // percent of cycles the receiver stalls
	int             rx_hold;  // long receiver hold-off, in cycles
	int             cycles;

	pcode_stack_machine_step_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_pcode_stack_machine_step_core NOT OK");
			$finish;
		end
	end

	// result side: accept and check
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// receiver back-pressure
	initial begin
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_axis_tready <= 0;
				rx_hold = rx_hold - 1;
			end else
				m_axis_tready <= ($urandom_range(0, 99) >= rx_stall);
		end
	end

	task automatic send_item(bit [2:0] op, bit [1:0] lev, bit [31:0] opd);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {3'd0, opd, lev, op};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item({3'd0, opd, lev, op});
		@(negedge clk);
	endtask

	// issue an item only if it reads no undefined word
	task automatic try_item(bit [2:0] op, bit [1:0] lev, bit [31:0] opd, output bit ok);
		step_out_t r;
		bit bad;
		trial.copy_from(shadow);
		trial.exec(op, lev, opd, r, bad);
		ok = !bad;
		if (ok) begin
			shadow.copy_from(trial);
			send_item(op, lev, opd);
		end
	endtask

	// fall back to an allocation that lands the top on word 1
	task automatic safe_item();
		bit ok;
		try_item(OP_INT, 2'($urandom), 32'(1 - int'(shadow.top)), ok);
	endtask

	task automatic directed_item(bit [2:0] op, bit [1:0] lev, bit [31:0] opd);
		bit ok;
		try_item(op, lev, opd, ok);
		if (!ok)
			safe_item();
	endtask

	function automatic bit [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return $urandom;
			default: return 32'($urandom_range(0, 20)) - 32'd5;
		endcase
	endfunction

	task automatic random_item();
		bit [2:0]  op;
		bit [1:0]  lev;
		bit [31:0] opd;
		bit        ok;
		int        w;
		for (int k = 0; k < 20; k++) begin
			w = $urandom_range(0, 99);
			lev = $urandom_range(0, 9) < 6 ? 2'd0 : 2'($urandom);
			if (w < 25) begin
				op = OP_LIT;
				opd = pick_word();
			end else if (w < 55) begin
				op = OP_OPR;
				opd = $urandom_range(0, 9) == 0 ? 32'($urandom) : 32'($urandom_range(0, 12));
			end else if (w < 65) begin
				op = OP_LOD;
				opd = $urandom_range(0, 19) == 0 ? 32'($urandom) : 32'($urandom_range(0, 6));
			end else if (w < 75) begin
				op = OP_STO;
				opd = $urandom_range(0, 19) == 0 ? 32'($urandom) : 32'($urandom_range(0, 6));
			end else if (w < 81) begin
				op = OP_CAL;
				opd = $urandom;
			end else if (w < 87) begin
				op = OP_INT;
				opd = $urandom_range(0, 19) == 0 ? 32'($urandom)
					: 32'($urandom_range(0, 6)) - 32'd2;
			end else if (w < 92) begin
				op = OP_JMP;
				opd = $urandom;
			end else begin
				op = OP_JPC;
				opd = $urandom;
			end
			try_item(op, lev, opd, ok);
			if (ok)
				return;
		end
		safe_item();
	endtask

	// sender goes quiet until every expected result is back
	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		sb = new();
		shadow = new();
		trial = new();
		tx_idle = 0;
		rx_stall = 0;
		rx_hold = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: word extremes, each opcode, divide corners, call and return
		directed_item(OP_LIT, 2'd0, 32'h8000_0000);
		directed_item(OP_LIT, 2'd3, '1);
		directed_item(OP_OPR, 2'd0, OPR_DIV);      // most negative over minus one
		directed_item(OP_LIT, 2'd0, 32'd0);
		directed_item(OP_OPR, 2'd0, OPR_DIV);      // divide by zero
		directed_item(OP_LIT, 2'd1, 32'h7FFF_FFFF);
		directed_item(OP_OPR, 2'd0, OPR_NEG);
		directed_item(OP_OPR, 2'd0, OPR_ODD);
		directed_item(OP_LIT, 2'd2, 32'd9);
		directed_item(OP_OPR, 2'd0, OPR_MUL);
		directed_item(OP_OPR, 2'd0, '1);           // unknown operation number
		directed_item(OP_CAL, 2'd1, 32'd100);
		directed_item(OP_INT, 2'd0, 32'd3);
		directed_item(OP_LOD, 2'd3, 32'd2);        // static link walk of the greatest level
		directed_item(OP_STO, 2'd0, 32'd3);
		directed_item(OP_OPR, 2'd0, OPR_RET);
		directed_item(OP_JPC, 2'd0, 32'd0);
		directed_item(OP_JMP, 2'd0, 32'd0);        // halt
		directed_item(OP_LOD, 2'd0, 32'hFFFF_FFF0); // read below the stack
		directed_item(OP_INT, 2'd0, 32'hFFFF_FC00); // top out of range
		directed_item(OP_LIT, 2'd0, 32'd1);
		directed_item(OP_STO, 2'd0, 32'd600);      // write above the stack
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle = 0;  rx_stall = 0;  end
				1: begin tx_idle = 52; rx_stall = 0;  end
				2: begin tx_idle = 0;  rx_stall = 52; end
				default: begin tx_idle = 12; rx_stall = 12; end
			endcase
			for (int n = 0; n < RUN_ITEMS; n++) begin
				if (ph == 2 && n == 100)
					rx_hold = 300;                  // receiver holds off, input backs up
				random_item();
			end
			drain();                                // sender pauses for every result
		end

		repeat (100) @(negedge clk);
		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("tb_pcode_stack_machine_step_core OK");
		else
			$display("tb_pcode_stack_machine_step_core NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/pcsm_pkg.sv
hdl/pcsm_ram.sv
hdl/pcsm_ctrl.sv
hdl/pcsm_dpath.sv
hdl/pcode_stack_machine_step_core.sv
tb/sv/tb_pcode_stack_machine_step_core.sv
